### src/tlwn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlwn_pkg
// Shared types, codes and helpers of the text line whitespace normaliser.
// ----------------------------------------------------------------------------
package tlwn_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam logic [3:0] TAB_WIDTH_RST = 4'd2;

  localparam logic [2:0] CFG_FOLD_CASE     = 3'd0;
  localparam logic [2:0] CFG_DROP_ALL      = 3'd1;
  localparam logic [2:0] CFG_COLLAPSE      = 3'd2;
  localparam logic [2:0] CFG_EXPAND_TABS   = 3'd3;
  localparam logic [2:0] CFG_TRIM_TRAILING = 3'd4;
  localparam logic [2:0] CFG_SKIP_BLANK    = 3'd5;
  localparam logic [2:0] CFG_TAB_WIDTH     = 3'd6;

  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_EMIT,
    OP_SPACES,
    OP_HOLD,
    OP_FLUSH,
    OP_EOL
  } op_t;

  typedef enum logic [1:0] {
    WS_SPACE,
    WS_TAB,
    WS_NL
  } ws_code_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [3:0] n;
    logic       blank;
    logic       need_out;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    logic       last;
    logic       ovf;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  function automatic logic [7:0] fold_lc(input logic [7:0] c, input logic en);
    if (en && (c >= CH_UP_A) && (c <= CH_UP_Z)) begin
      return c + CASE_GAP;
    end
    return c;
  endfunction

  function automatic ws_code_t ws_enc(input logic [7:0] c);
    ws_code_t k;
    unique case (c)
      CH_TAB:  k = WS_TAB;
      CH_NL:   k = WS_NL;
      default: k = WS_SPACE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] ws_dec(input ws_code_t k);
    logic [7:0] c;
    unique case (k)
      WS_TAB:  c = CH_TAB;
      WS_NL:   c = CH_NL;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

endpackage

### src/text_line_whitespace_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_whitespace_normalizer_top
// Normalises text lines byte by byte: case folding, whitespace drop/collapse,
// tab expansion, trailing whitespace trimming and blank line skipping.
//
//   channel  handshake        payload
//   input    push / full      in_action, in_char_in
//   result   pop / empty      out_char_out, out_line_end, out_last,
//                             out_trim_overflow
//   config   cfg_we           cfg_index, cfg_data
//
// An expanded tab is emitted or held as tab_width spaces, and as none when
// tab_width is zero. A flush replays the held store and then emits its byte;
// a store read waits when the store was written in the previous cycle.
// Reset is synchronous; no clearing pass, the held store is filled before use.
// The command queue decouples intake from a stalled back end or result port.
// ----------------------------------------------------------------------------
module text_line_whitespace_normalizer_top #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_action,
  input  logic [7:0] in_char_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_out,
  output logic       out_line_end,
  output logic       out_last,
  output logic       out_trim_overflow,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [3:0] cfg_data
);

  import tlwn_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_push;
  logic cmd_empty;
  logic cmd_pop;
  res_t res_in;
  res_t res_head;
  logic res_push;
  logic res_full;

  tlwn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .in_action  (in_action),
    .in_char_in (in_char_in),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  tlwn_fifo #(
    .DEPTH (CMD_Q_DEPTH),
    .T     (cmd_t)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  tlwn_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_head),
    .cmd_valid (!cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  tlwn_fifo #(
    .DEPTH (RES_Q_DEPTH),
    .T     (res_t)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign out_char_out      = res_head.ch;
  assign out_line_end      = res_head.line_end;
  assign out_last          = res_head.last;
  assign out_trim_overflow = res_head.ovf;

  a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  a_line_end_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_line_end) |-> (out_char_out == 8'd0 && out_last))
    else $error("line end result malformed");

endmodule

### src/tlwn_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlwn_fifo
// Small register queue used between the front, the back and the result port.
// ----------------------------------------------------------------------------
module tlwn_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  T     wr_data,
  output logic full,
  input  logic rd_en,
  output T     rd_data,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr;
  logic            do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### src/tlwn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlwn_front
// Configuration registers and per-byte classification into back-end commands.
// ----------------------------------------------------------------------------
module tlwn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic              push,
  input  logic              full,
  input  logic              in_action,
  input  logic [7:0]        in_char_in,
  output logic              cmd_push,
  output tlwn_pkg::cmd_t    cmd
);

  import tlwn_pkg::*;

  logic       fold_r;
  logic       drop_r;
  logic       collapse_r;
  logic       expand_r;
  logic       trim_r;
  logic       skip_r;
  logic [3:0] tab_w_r;
  logic       prev_ws_r;
  logic       prev_ws_nxt;
  logic       had_in_r;
  logic       had_in_nxt;
  logic [7:0] c;
  logic       ws;
  logic       tab_x;

  assign cmd_push = push && !full;
  assign c        = fold_lc(in_char_in, fold_r);
  assign ws       = is_ws(c);
  assign tab_x    = (c == CH_TAB) && expand_r;

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NOP;
    cmd.ch       = c;
    cmd.n        = 4'd1;
    prev_ws_nxt  = prev_ws_r;
    had_in_nxt   = had_in_r;
    if (in_action) begin
      cmd.op       = OP_EOL;
      cmd.ch       = '0;
      cmd.blank    = !had_in_r && skip_r;
      cmd.need_out = drop_r;
      prev_ws_nxt  = 1'b0;
      had_in_nxt   = 1'b0;
    end else begin
      had_in_nxt  = 1'b1;
      prev_ws_nxt = ws;
      if (drop_r) begin
        cmd.op = ws ? OP_NOP : OP_EMIT;
      end else if (collapse_r) begin
        cmd.op = (ws && prev_ws_r) ? OP_NOP : OP_EMIT;
      end else if (trim_r) begin
        if (ws) begin
          cmd.op = OP_HOLD;
          if (tab_x) begin
            cmd.ch = CH_SPACE;
            cmd.n  = tab_w_r;
          end
        end else begin
          cmd.op = OP_FLUSH;
        end
      end else if (tab_x) begin
        cmd.op = OP_SPACES;
        cmd.ch = CH_SPACE;
        cmd.n  = tab_w_r;
      end else begin
        cmd.op = OP_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r     <= 1'b0;
      drop_r     <= 1'b0;
      collapse_r <= 1'b0;
      expand_r   <= 1'b0;
      trim_r     <= 1'b0;
      skip_r     <= 1'b0;
      tab_w_r    <= TAB_WIDTH_RST;
      prev_ws_r  <= 1'b0;
      had_in_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FOLD_CASE:     fold_r     <= cfg_data[0];
          CFG_DROP_ALL:      drop_r     <= cfg_data[0];
          CFG_COLLAPSE:      collapse_r <= cfg_data[0];
          CFG_EXPAND_TABS:   expand_r   <= cfg_data[0];
          CFG_TRIM_TRAILING: trim_r     <= cfg_data[0];
          CFG_SKIP_BLANK:    skip_r     <= cfg_data[0];
          CFG_TAB_WIDTH:     tab_w_r    <= cfg_data;
          default:           ;
        endcase
      end
      if (cmd_push) begin
        prev_ws_r <= prev_ws_nxt;
        had_in_r  <= had_in_nxt;
      end
    end
  end

endmodule

### src/tlwn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlwn_back
// Command execution: held whitespace store, repeats, flushes and line ends.
// ----------------------------------------------------------------------------
module tlwn_back #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tlwn_pkg::cmd_t    cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output tlwn_pkg::res_t    res
);

  import tlwn_pkg::*;

  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  ws_code_t       hold_mem [HOLD_DEPTH];
  ws_code_t       mem_q;
  logic           mem_we;
  logic [AW-1:0]  rd_addr;
  logic           q_ok_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  cnt_nxt;
  logic [CW-1:0]  idx_r;
  logic [CW-1:0]  idx_nxt;
  logic [3:0]     stp_r;
  logic [3:0]     stp_nxt;
  logic           ovf_r;
  logic           ovf_nxt;
  logic           lho_r;
  logic           lho_nxt;
  logic           last_step;
  logic           keep;

  assign last_step = (stp_r == (cmd.n - 4'd1));
  assign keep      = !cmd.blank && !(cmd.need_out && !lho_r);
  assign rd_addr   = idx_nxt[AW-1:0];

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    res      = '0;
    res.ovf  = ovf_r;
    mem_we   = 1'b0;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    stp_nxt  = stp_r;
    ovf_nxt  = ovf_r;
    lho_nxt  = lho_r;
    if (cmd_valid) begin
      unique case (cmd.op)
        OP_NOP: begin
          cmd_pop = 1'b1;
          cnt_nxt = '0;
        end
        OP_EMIT: begin
          if (!res_full) begin
            res_push = 1'b1;
            res.ch   = cmd.ch;
            res.last = 1'b1;
            cmd_pop  = 1'b1;
            cnt_nxt  = '0;
          end
        end
        OP_SPACES: begin
          if (cmd.n == 4'd0) begin
            cmd_pop = 1'b1;
            cnt_nxt = '0;
          end else if (!res_full) begin
            res_push = 1'b1;
            res.ch   = cmd.ch;
            res.last = last_step;
            if (last_step) begin
              cmd_pop = 1'b1;
              cnt_nxt = '0;
              stp_nxt = '0;
            end else begin
              stp_nxt = stp_r + 4'd1;
            end
          end
        end
        OP_HOLD: begin
          if (cmd.n == 4'd0) begin
            cmd_pop = 1'b1;
          end else if (cnt_r < CW'(HOLD_DEPTH) || !res_full) begin
            if (cnt_r < CW'(HOLD_DEPTH)) begin
              mem_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              ovf_nxt  = 1'b1;
              res_push = 1'b1;
              res.ch   = cmd.ch;
              res.ovf  = 1'b1;
              res.last = last_step;
            end
            if (last_step) begin
              cmd_pop = 1'b1;
              stp_nxt = '0;
            end else begin
              stp_nxt = stp_r + 4'd1;
            end
          end
        end
        OP_FLUSH: begin
          if (idx_r != cnt_r) begin
            if (q_ok_r && !res_full) begin
              res_push = 1'b1;
              res.ch   = ws_dec(mem_q);
              idx_nxt  = idx_r + 1'b1;
            end
          end else if (!res_full) begin
            res_push = 1'b1;
            res.ch   = cmd.ch;
            res.last = 1'b1;
            cmd_pop  = 1'b1;
            cnt_nxt  = '0;
            idx_nxt  = '0;
          end
        end
        OP_EOL: begin
          if (!keep || !res_full) begin
            if (keep) begin
              res_push     = 1'b1;
              res.line_end = 1'b1;
              res.last     = 1'b1;
            end
            cmd_pop = 1'b1;
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            lho_nxt = 1'b0;
          end
        end
        default: begin
          cmd_pop = 1'b1;
        end
      endcase
    end
    if (res_push && !res.line_end) begin
      lho_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hold_mem[cnt_r[AW-1:0]] <= ws_enc(cmd.ch);
    end
    mem_q <= hold_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_ok_r <= 1'b0;
      cnt_r  <= '0;
      idx_r  <= '0;
      stp_r  <= '0;
      ovf_r  <= 1'b0;
      lho_r  <= 1'b0;
    end else begin
      q_ok_r <= !mem_we;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
      stp_r  <= stp_nxt;
      ovf_r  <= ovf_nxt;
      lho_r  <= lho_nxt;
    end
  end

endmodule

### sim/tb_text_line_whitespace_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_line_whitespace_normalizer_top
// Self-checking bench for the text line whitespace normaliser. Lines of bytes
// are queued in under every whitespace mode, including a zero tab width and
// a mode change in mid-line. Each accepted transaction is run through a
// behavioural normaliser, and the bytes and line ends it predicts are matched
// field by field against the popped results. Both queue sides stall at
// random, and a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module tb_text_line_whitespace_normalizer_top;
  import tlwn_pkg::*;

  localparam int   TRAIL_DEPTH    = 32;
  localparam int   SETTLE_CYCLES  = 100;
  localparam int   WATCHDOG_LIMIT = 3000;
  localparam logic ACT_BYTE       = 1'b0;
  localparam logic ACT_EOL        = 1'b1;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic       in_action;
  logic [7:0] in_char_in;
  logic       empty;
  logic       pop;
  logic [7:0] out_char_out;
  logic       out_line_end;
  logic       out_last;
  logic       out_trim_overflow;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [3:0] cfg_data;

  // normaliser settings as last written
  logic       cf_fold;
  logic       cf_drop;
  logic       cf_collapse;
  logic       cf_expand;
  logic       cf_trim;
  logic       cf_skip;
  logic [3:0] cf_tabw;

  // line state of the behavioural normaliser
  logic       last_was_ws;
  logic       line_got_byte;
  logic       line_gave_byte;
  logic [7:0] trail_ws [TRAIL_DEPTH];
  int         trail_cnt;
  logic       trail_ovf;
  int         produced;

  res_t       expected_norm [$];
  int         fail_count;
  int         quiet_cycles;
  logic       feed_burst;
  logic       sink_burst;

  text_line_whitespace_normalizer_top #(
    .HOLD_DEPTH(TRAIL_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_action        (in_action),
    .in_char_in       (in_char_in),
    .empty            (empty),
    .pop              (pop),
    .out_char_out     (out_char_out),
    .out_line_end     (out_line_end),
    .out_last         (out_last),
    .out_trim_overflow(out_trim_overflow),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void put_result(input logic [7:0] ch, input logic le);
    res_t r;
    r.ch       = ch;
    r.line_end = le;
    r.last     = 1'b0;
    r.ovf      = trail_ovf;
    expected_norm = {expected_norm, r};
    produced++;
    if (!le) begin
      line_gave_byte = 1'b1;
    end
  endfunction

  function automatic void hold_ws(input logic [7:0] c);
    if (trail_cnt < TRAIL_DEPTH) begin
      trail_ws[trail_cnt] = c;
      trail_cnt++;
    end else begin
      trail_ovf = 1'b1;
      put_result(c, 1'b0);
    end
  endfunction

  function automatic void normalize_item(input logic act, input logic [7:0] ch);
    logic [7:0] c;
    logic       ws;
    res_t       r;
    produced = 0;
    if (act == ACT_EOL) begin
      if (!((!line_got_byte && cf_skip) || (cf_drop && !line_gave_byte))) begin
        put_result(8'h00, 1'b1);
      end
      last_was_ws    = 1'b0;
      line_got_byte  = 1'b0;
      line_gave_byte = 1'b0;
      trail_cnt      = 0;
      trail_ovf      = 1'b0;
    end else begin
      c = ch;
      line_got_byte = 1'b1;
      if (cf_fold && c >= CH_UP_A && c <= CH_UP_Z) begin
        c = c + CASE_GAP;
      end
      ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
      if (cf_drop) begin
        trail_cnt = 0;
        if (!ws) begin
          put_result(c, 1'b0);
        end
      end else if (cf_collapse) begin
        trail_cnt = 0;
        if (!(ws && last_was_ws)) begin
          put_result(c, 1'b0);
        end
      end else if (cf_trim) begin
        if (ws) begin
          if (c == CH_TAB && cf_expand) begin
            for (int k = 0; k < int'(cf_tabw); k++) begin
              hold_ws(CH_SPACE);
            end
          end else begin
            hold_ws(c);
          end
        end else begin
          for (int k = 0; k < trail_cnt; k++) begin
            put_result(trail_ws[k], 1'b0);
          end
          trail_cnt = 0;
          put_result(c, 1'b0);
        end
      end else begin
        trail_cnt = 0;
        if (c == CH_TAB && cf_expand) begin
          for (int k = 0; k < int'(cf_tabw); k++) begin
            put_result(CH_SPACE, 1'b0);
          end
        end else begin
          put_result(c, 1'b0);
        end
      end
      last_was_ws = ws;
    end
    if (produced > 0) begin
      r = expected_norm.pop_back();
      r.last = 1'b1;
      expected_norm = {expected_norm, r};
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_item(input logic act, input logic [7:0] ch);
    int gap;
    if ($urandom_range(0, 31) == 0) begin
      feed_burst = !feed_burst;
    end
    gap = feed_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push       <= 1'b1;
    in_action  <= act;
    in_char_in <= ch;
    do @(posedge clk); while (full);
    normalize_item(act, ch);
    @(negedge clk);
  endtask

  task automatic cfg_put(input logic [2:0] idx, input logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic set_config(input logic fold, input logic drop, input logic coll,
                            input logic expand, input logic trim, input logic skip,
                            input logic [3:0] tabw);
    cfg_put(CFG_FOLD_CASE, {3'b000, fold});
    cfg_put(CFG_DROP_ALL, {3'b000, drop});
    cfg_put(CFG_COLLAPSE, {3'b000, coll});
    cfg_put(CFG_EXPAND_TABS, {3'b000, expand});
    cfg_put(CFG_TRIM_TRAILING, {3'b000, trim});
    cfg_put(CFG_SKIP_BLANK, {3'b000, skip});
    cfg_put(CFG_TAB_WIDTH, tabw);
    cfg_we      <= 1'b0;
    cf_fold     = fold;
    cf_drop     = drop;
    cf_collapse = coll;
    cf_expand   = expand;
    cf_trim     = trim;
    cf_skip     = skip;
    cf_tabw     = tabw;
  endtask

  // hold the input side until every result has drained and the back end is quiet
  task automatic settle();
    push <= 1'b0;
    while (expected_norm.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(0, 5))
      0:       return CH_TAB;
      1:       return CH_NL;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return CH_UP_A + 8'($urandom_range(0, 25));
      3, 4:    return CH_UP_A + CASE_GAP + 8'($urandom_range(0, 25));
      5, 6, 7: return pick_ws();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_defaults();
    send_item(ACT_BYTE, "A");
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, CH_TAB);
    send_item(ACT_BYTE, CH_NL);
    send_item(ACT_EOL, 8'hFF);
  endtask

  task automatic test_fold_and_drop();
    settle();
    set_config(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd2);
    send_item(ACT_BYTE, "Z");
    send_item(ACT_BYTE, CH_SPACE);
    send_item(ACT_EOL, 8'h00);
    send_item(ACT_BYTE, CH_SPACE);
    send_item(ACT_EOL, 8'h00);
    send_item(ACT_EOL, 8'hA5);
  endtask

  task automatic test_trim_overflow();
    settle();
    set_config(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 4'd8);
    repeat (5) send_item(ACT_BYTE, CH_TAB);
    send_item(ACT_BYTE, "x");
    send_item(ACT_BYTE, CH_SPACE);
    send_item(ACT_EOL, 8'h5A);
  endtask

  task automatic test_mode_switch();
    settle();
    set_config(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 4'd0);
    send_item(ACT_BYTE, "a");
    send_item(ACT_BYTE, CH_TAB);
    send_item(ACT_BYTE, CH_SPACE);
    settle();
    set_config(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0);
    send_item(ACT_BYTE, CH_SPACE);
    send_item(ACT_BYTE, "B");
    send_item(ACT_EOL, 8'h00);
    settle();
    set_config(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0);
    send_item(ACT_EOL, 8'h00);
  endtask

  task automatic run_lines(input int quota);
    int sent;
    int len;
    int run;
    sent = 0;
    while (sent < quota) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      for (int k = 0; k < len && sent < quota; k++) begin
        send_item(ACT_BYTE, pick_char());
        sent++;
      end
      if ($urandom_range(0, 7) == 0) begin
        run = $urandom_range(30, 40);
        for (int k = 0; k < run && sent < quota; k++) begin
          send_item(ACT_BYTE, pick_ws());
          sent++;
        end
      end
      if (sent < quota && $urandom_range(0, 15) != 0) begin
        send_item(ACT_EOL, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  task automatic test_random_modes();
    logic [3:0] tabw;
    for (int p = 0; p < 8; p++) begin
      settle();
      tabw = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 8));
      case (p)
        0:       set_config(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd1);
        1:       set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 4'd8);
        2:       set_config(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 4'd8);
        3:       set_config(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd3);
        default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) == 0),
                            1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)),
                            tabw);
      endcase
      run_lines(43);
    end
  endtask

  initial begin : result_sink
    int   stall;
    res_t want;
    pop = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) begin
        sink_burst = !sink_burst;
      end
      stall = sink_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (expected_norm.size() == 0) begin
        $display("%0t unexpected transaction: expected none, actual %h %b %b %b", $time,
                 out_char_out, out_line_end, out_last, out_trim_overflow);
        fail_count++;
      end else begin
        want = expected_norm.pop_front();
        check_field("char_out", want.ch, out_char_out);
        check_field("line_end", {7'd0, want.line_end}, {7'd0, out_line_end});
        check_field("last", {7'd0, want.last}, {7'd0, out_last});
        check_field("trim_overflow", {7'd0, want.ovf}, {7'd0, out_trim_overflow});
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    push           = 1'b0;
    in_action      = 1'b0;
    in_char_in     = 8'h00;
    cfg_we         = 1'b0;
    cfg_index      = CFG_FOLD_CASE;
    cfg_data       = 4'd0;
    fail_count     = 0;
    feed_burst     = 1'b0;
    sink_burst     = 1'b0;
    cf_fold        = 1'b0;
    cf_drop        = 1'b0;
    cf_collapse    = 1'b0;
    cf_expand      = 1'b0;
    cf_trim        = 1'b0;
    cf_skip        = 1'b0;
    cf_tabw        = TAB_WIDTH_RST;
    last_was_ws    = 1'b0;
    line_got_byte  = 1'b0;
    line_gave_byte = 1'b0;
    trail_cnt      = 0;
    trail_ovf      = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_defaults();
    test_fold_and_drop();
    test_trim_overflow();
    test_mode_switch();
    test_random_modes();
    settle();
    if (fail_count == 0 && expected_norm.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
